/* src/lrs_pkg.sv */
// lrs_pkg: shared constants, payload structs and the digit extract function
// for the radix sort block. No dependencies.
package lrs_pkg;

   localparam int MAX_ENTRIES  = 64;
   localparam int DIGIT_BITS   = 8;
   localparam int KEY_BITS     = 64;
   localparam int PAYLOAD_BITS = 32;
   localparam int NUM_PASSES   = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int NUM_BINS     = 1 << DIGIT_BITS;
   localparam int IDX_W        = $clog2(MAX_ENTRIES);
   localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
   localparam int PASS_W       = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;
   localparam int SHIFT_W      = $clog2(KEY_BITS);
   // an odd number of passes leaves the sorted run in buffer b
   localparam logic RESULT_IN_B = ((NUM_PASSES % 2) == 1);

   typedef struct packed {
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
      logic                    final_entry;
   } lrs_req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]     sorted_key;
      logic [PAYLOAD_BITS-1:0] sorted_payload;
      logic                    last_out;
   } lrs_rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } lrs_entry_type;

   typedef struct packed {
      logic lookup;     // read the bin this cycle, update it next cycle
      logic clear_wr;   // zero the count of the bin
      logic scatter;    // lookups go to the offset table
      logic prefix;     // lookups feed the running sum
      logic pfx_start;  // zero the running sum
   } lrs_hist_ctl_type;

   function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [KEY_BITS-1:0] key,
                                                      input logic [PASS_W-1:0]   pass);
      logic [KEY_BITS-1:0] shifted;
      shifted = key >> (SHIFT_W'(pass) * SHIFT_W'(DIGIT_BITS));
      return shifted[DIGIT_BITS-1:0];
   endfunction

endpackage

/* src/lrs_entry_buf.sv */
// lrs_entry_buf: one ping-pong entry buffer, one write and one registered read port.
// Depends on lrs_pkg.
module lrs_entry_buf (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [lrs_pkg::IDX_W-1:0]  wr_addr,
   input  lrs_pkg::lrs_entry_type     wr_data,
   input  logic                       rd_en,
   input  logic [lrs_pkg::IDX_W-1:0]  rd_addr,
   output lrs_pkg::lrs_entry_type     rd_data
);
   import lrs_pkg::*;

   lrs_entry_type mem [MAX_ENTRIES];
   lrs_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/lrs_hist_unit.sv */
// lrs_hist_unit: digit histogram and offset tables with the shared
// read-increment-write unit, prefix sum accumulator and write forwarding.
// Depends on lrs_pkg.
module lrs_hist_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  lrs_pkg::lrs_hist_ctl_type      ctl,
   input  logic [lrs_pkg::DIGIT_BITS-1:0] bin,
   output logic                           busy,
   output logic [lrs_pkg::CNT_W-1:0]      pos
);
   import lrs_pkg::*;

   logic [CNT_W-1:0]      cnt_mem [NUM_BINS];
   logic [CNT_W-1:0]      off_mem [NUM_BINS];
   logic [CNT_W-1:0]      cnt_rd_ff;
   logic [CNT_W-1:0]      off_rd_ff;
   logic                  s2_vld_ff;
   logic                  s2_scatter_ff;
   logic                  s2_prefix_ff;
   logic [DIGIT_BITS-1:0] s2_bin_ff;
   logic                  fw_vld_ff;
   logic [DIGIT_BITS-1:0] fw_bin_ff;
   logic [CNT_W-1:0]      fw_val_ff;
   logic [CNT_W-1:0]      run_ff;
   logic [CNT_W-1:0]      run_in;
   logic [CNT_W-1:0]      cur;
   logic [CNT_W-1:0]      nxt;
   logic                  cnt_we;
   logic [DIGIT_BITS-1:0] cnt_wa;
   logic [CNT_W-1:0]      cnt_wd;
   logic                  off_we;
   logic [CNT_W-1:0]      off_wd;

   always_comb begin
      // the bin written last cycle is not yet in the read data
      if (fw_vld_ff && (fw_bin_ff == s2_bin_ff)) begin
         cur = fw_val_ff;
      end else if (s2_scatter_ff) begin
         cur = off_rd_ff;
      end else begin
         cur = cnt_rd_ff;
      end
      nxt    = cur + CNT_W'(1);
      cnt_we = 1'b0;
      cnt_wa = s2_bin_ff;
      cnt_wd = nxt;
      off_we = 1'b0;
      off_wd = nxt;
      run_in = run_ff;
      if (ctl.clear_wr) begin
         cnt_we = 1'b1;
         cnt_wa = bin;
         cnt_wd = '0;
      end else if (s2_vld_ff) begin
         if (s2_prefix_ff) begin
            // offset gets the running sum, count is cleared for the next pass
            cnt_we = 1'b1;
            cnt_wd = '0;
            off_we = 1'b1;
            off_wd = run_ff;
            run_in = run_ff + cnt_rd_ff;
         end else if (s2_scatter_ff) begin
            off_we = 1'b1;
         end else begin
            cnt_we = 1'b1;
         end
      end
      if (ctl.pfx_start) begin
         run_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (off_we) begin
         off_mem[s2_bin_ff] <= off_wd;
      end
      if (ctl.lookup && !ctl.scatter) begin
         cnt_rd_ff <= cnt_mem[bin];
      end
      if (ctl.lookup && ctl.scatter) begin
         off_rd_ff <= off_mem[bin];
      end
      s2_bin_ff     <= bin;
      s2_scatter_ff <= ctl.scatter;
      s2_prefix_ff  <= ctl.prefix;
      fw_bin_ff     <= s2_bin_ff;
      fw_val_ff     <= nxt;
      run_ff        <= run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         fw_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= ctl.lookup;
         fw_vld_ff <= s2_vld_ff && !s2_prefix_ff;
      end
   end

   assign busy = s2_vld_ff;
   assign pos  = cur;

endmodule

/* src/lsd_radix_sort_64bit_keys_top.sv */
// Radix sort block top level: sequencer, ping-pong entry buffers and histogram unit.
// Depends on lrs_pkg, lrs_entry_buf and lrs_hist_unit.
//
// Entries are taken one per cycle into buffer a until the entry with final_entry set;
// at most 64 are kept and later ones are dropped, while the final one still starts the
// sort. The sort runs eight passes of one 8-bit digit each, least significant first,
// and is stable. Each pass makes one sweep over the n stored entries to count digits,
// one sweep over all 256 bins for the exclusive prefix sum, and one sweep over the
// entries to scatter them into the other buffer, all through one shared
// read-increment-write unit on the bin tables. The sorted entries then leave one per
// cycle when not stalled, the first after the S_OUT_RD read state, the last one flagged
// by last_out. No entry is accepted from the final entry until the last result transfer.
// After reset the block clears every bin of the histogram table in the S_CLEAR state
// before it takes the first entry.
module lsd_radix_sort_64bit_keys_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lrs_pkg::lrs_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lrs_pkg::lrs_rsp_type rsp_data
);
   import lrs_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR   = 7'b0000001,
      S_COLLECT = 7'b0000010,
      S_COUNT   = 7'b0000100,
      S_PREFIX  = 7'b0001000,
      S_SCATTER = 7'b0010000,
      S_OUT_RD  = 7'b0100000,
      S_OUT     = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [PASS_W-1:0]     pass_ff, pass_in;
   logic [CNT_W-1:0]      iss_ff, iss_in;
   logic                  p1_ff, p1_in;
   logic [DIGIT_BITS:0]   bin_ff, bin_in;
   logic [IDX_W-1:0]      out_idx_ff, out_idx_in;
   lrs_entry_type         ent_s2_ff;

   logic                  req_xfer;
   logic                  rsp_xfer;
   logic                  src_is_b;
   logic                  issue;
   logic                  walk_done;
   logic                  out_last;
   logic                  out_rd;
   logic [IDX_W-1:0]      out_addr;
   logic                  scat_wr;
   logic                  collect_wr;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_addr;
   lrs_entry_type         wr_data;
   lrs_entry_type         a_rd_data;
   lrs_entry_type         b_rd_data;
   lrs_entry_type         src_rdata;
   lrs_entry_type         res_rdata;
   logic                  a_wr_en, a_rd_en;
   logic                  b_wr_en, b_rd_en;
   lrs_hist_ctl_type      hctl;
   logic [DIGIT_BITS-1:0] hbin;
   logic                  hbusy;
   logic [CNT_W-1:0]      hpos;

   always_comb begin
      req_stall  = (state_ff != S_COLLECT);
      req_xfer   = req_valid && !req_stall;
      rsp_valid  = (state_ff == S_OUT);
      rsp_xfer   = rsp_valid && !rsp_stall;
      src_is_b   = pass_ff[0];
      src_rdata  = src_is_b ? b_rd_data : a_rd_data;
      res_rdata  = RESULT_IN_B ? b_rd_data : a_rd_data;
      issue      = ((state_ff == S_COUNT) || (state_ff == S_SCATTER)) && (iss_ff != cnt_ff);
      walk_done  = (iss_ff == cnt_ff) && !p1_ff && !hbusy;
      out_last   = (CNT_W'(out_idx_ff) == (cnt_ff - CNT_W'(1)));
      out_rd     = (state_ff == S_OUT_RD) || (rsp_xfer && !out_last);
      out_addr   = (state_ff == S_OUT_RD) ? '0 : out_idx_ff + IDX_W'(1);
      rd_addr    = out_rd ? out_addr : iss_ff[IDX_W-1:0];
      scat_wr    = (state_ff == S_SCATTER) && hbusy;
      collect_wr = req_xfer && (cnt_ff < CNT_W'(MAX_ENTRIES));
      wr_addr    = (state_ff == S_COLLECT) ? cnt_ff[IDX_W-1:0] : hpos[IDX_W-1:0];
      if (state_ff == S_COLLECT) begin
         wr_data.key     = req_data.key;
         wr_data.payload = req_data.payload;
      end else begin
         wr_data = ent_s2_ff;
      end
      a_wr_en = collect_wr || (scat_wr && src_is_b);
      b_wr_en = scat_wr && !src_is_b;
      a_rd_en = (issue && !src_is_b) || (out_rd && !RESULT_IN_B);
      b_rd_en = (issue && src_is_b) || (out_rd && RESULT_IN_B);
   end

   always_comb begin
      hctl.lookup    = (p1_ff && ((state_ff == S_COUNT) || (state_ff == S_SCATTER)))
                       || ((state_ff == S_PREFIX) && !bin_ff[DIGIT_BITS]);
      hctl.clear_wr  = (state_ff == S_CLEAR) && !bin_ff[DIGIT_BITS];
      hctl.scatter   = (state_ff == S_SCATTER);
      hctl.prefix    = (state_ff == S_PREFIX);
      hctl.pfx_start = (state_ff == S_COUNT) && walk_done;
      if ((state_ff == S_PREFIX) || (state_ff == S_CLEAR)) begin
         hbin = bin_ff[DIGIT_BITS-1:0];
      end else begin
         hbin = digit_of(src_rdata.key, pass_ff);
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      pass_in    = pass_ff;
      iss_in     = iss_ff;
      p1_in      = issue;
      bin_in     = bin_ff;
      out_idx_in = out_idx_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (bin_ff[DIGIT_BITS]) begin
               state_in = S_COLLECT;
            end else begin
               bin_in = bin_ff + (DIGIT_BITS + 1)'(1);
            end
         end
         S_COLLECT: begin
            if (req_xfer) begin
               if (collect_wr) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (req_data.final_entry) begin
                  state_in = S_COUNT;
                  pass_in  = '0;
                  iss_in   = '0;
               end
            end
         end
         S_COUNT: begin
            if (issue) begin
               iss_in = iss_ff + CNT_W'(1);
            end
            if (walk_done) begin
               state_in = S_PREFIX;
               bin_in   = '0;
            end
         end
         S_PREFIX: begin
            if (!bin_ff[DIGIT_BITS]) begin
               bin_in = bin_ff + (DIGIT_BITS + 1)'(1);
            end else if (!hbusy) begin
               state_in = S_SCATTER;
               iss_in   = '0;
            end
         end
         S_SCATTER: begin
            if (issue) begin
               iss_in = iss_ff + CNT_W'(1);
            end
            if (walk_done) begin
               iss_in = '0;
               if (pass_ff == PASS_W'(NUM_PASSES - 1)) begin
                  state_in   = S_OUT_RD;
                  out_idx_in = '0;
               end else begin
                  state_in = S_COUNT;
                  pass_in  = pass_ff + PASS_W'(1);
               end
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_xfer) begin
               if (out_last) begin
                  state_in = S_COLLECT;
                  cnt_in   = '0;
               end else begin
                  out_idx_in = out_idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         cnt_ff     <= '0;
         pass_ff    <= '0;
         iss_ff     <= '0;
         p1_ff      <= 1'b0;
         bin_ff     <= '0;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         pass_ff    <= pass_in;
         iss_ff     <= iss_in;
         p1_ff      <= p1_in;
         bin_ff     <= bin_in;
         out_idx_ff <= out_idx_in;
      end
   end

   // entry rides along to the cycle its scatter position is known
   always_ff @(posedge clock) begin
      if (p1_ff) begin
         ent_s2_ff <= src_rdata;
      end
   end

   lrs_entry_buf u_buf_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (a_rd_en),
      .rd_addr (rd_addr),
      .rd_data (a_rd_data)
   );

   lrs_entry_buf u_buf_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (b_rd_en),
      .rd_addr (rd_addr),
      .rd_data (b_rd_data)
   );

   lrs_hist_unit u_hist (
      .clock (clock),
      .reset (reset),
      .ctl   (hctl),
      .bin   (hbin),
      .busy  (hbusy),
      .pos   (hpos)
   );

   always_comb begin
      rsp_data.sorted_key     = res_rdata.key;
      rsp_data.sorted_payload = res_rdata.payload;
      rsp_data.last_out       = out_last;
   end

endmodule

/* src/lrs_checker.sv */
// lrs_checker: port-level checks on the radix sort top level, attached by bind.
// Depends on lrs_pkg and lsd_radix_sort_64bit_keys_top.
module lrs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input lrs_pkg::lrs_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input lrs_pkg::lrs_rsp_type rsp_data
);
   import lrs_pkg::*;

   // no results right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input is held off while results go out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while results pending");

   // the final entry closes the input until the run has been sorted and sent
   a_final_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.final_entry) |=> req_stall)
      else $error("input still open after final entry");

   // results of a run follow each other until the one flagged last
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_out) |=> rsp_valid)
      else $error("result run broken before last_out");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind lsd_radix_sort_64bit_keys_top lrs_checker u_lrs_checker (.*);

/* test/lsd_radix_sort_64bit_keys_top_test.sv */
// Self-checking testbench for the 64-bit key radix sort block.
// Depends on lrs_pkg and lsd_radix_sort_64bit_keys_top; runs entries through a stable sort
// predictor and checks every sorted result transfer in order.
module lsd_radix_sort_64bit_keys_top_test;
   import lrs_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 200;
   localparam int DRAIN_CYCLES = 300;
   localparam int NUM_ROWS     = 20;

   typedef lrs_entry_type entry_arr_type [MAX_ENTRIES];

   typedef struct packed {
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
      logic                    fin;
      logic                    exp_given;
      logic [KEY_BITS-1:0]     exp_key;
      logic [PAYLOAD_BITS-1:0] exp_payload;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   lrs_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   lrs_rsp_type rsp_data;

   entry_arr_type held_entries;
   int          held_count = 0;
   lrs_rsp_type sorted_due[$];
   lrs_rsp_type want;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          no_idle = 1'b0;

   stim_row_type directed_rows [NUM_ROWS] = '{
      // single-entry runs come straight back with last_out set
      '{64'h0, 32'h0, 1'b1, 1'b1, 64'h0, 32'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
        64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF},
      '{64'h8000_0000_0000_0001, 32'h8000_0001, 1'b1, 1'b1,
        64'h8000_0000_0000_0001, 32'h8000_0001},
      // mixed extremes with repeated keys
      '{64'h5, 32'd1, 1'b0, 1'b0, 64'h0, 32'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 32'd2, 1'b0, 1'b0, 64'h0, 32'h0},
      '{64'h5, 32'd3, 1'b0, 1'b0, 64'h0, 32'h0},
      '{64'h0, 32'd4, 1'b0, 1'b0, 64'h0, 32'h0},
      '{64'h0000_0000_0000_0100, 32'd5, 1'b0, 1'b0, 64'h0, 32'h0},
      '{64'h00FF_FFFF_FFFF_FFFF, 32'd6, 1'b0, 1'b0, 64'h0, 32'h0},
      '{64'h0100_0000_0000_0000, 32'd7, 1'b0, 1'b0, 64'h0, 32'h0},
      '{64'h8000_0000_0000_0000, 32'd8, 1'b0, 1'b0, 64'h0, 32'h0},
      '{64'h5, 32'd9, 1'b1, 1'b0, 64'h0, 32'h0},
      // two entries arriving in descending order
      '{64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 64'h0, 32'h0},
      '{64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 64'h0, 32'h0},
      // all keys equal, arrival order must hold
      '{64'h7, 32'd10, 1'b0, 1'b0, 64'h0, 32'h0},
      '{64'h7, 32'd11, 1'b0, 1'b0, 64'h0, 32'h0},
      '{64'h7, 32'd12, 1'b1, 1'b0, 64'h0, 32'h0},
      '{64'h0102_0304_0506_0708, 32'd0, 1'b0, 1'b0, 64'h0, 32'h0},
      '{64'h0807_0605_0403_0201, 32'd1, 1'b0, 1'b0, 64'h0, 32'h0},
      '{64'h0000_0000_0000_0100, 32'd2, 1'b1, 1'b0, 64'h0, 32'h0}
   };

   lsd_radix_sort_64bit_keys_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // keeps the entry, and on the last one of a run sorts what is kept, digit by digit
   task automatic store_entry(input lrs_req_type e, input bit queue_sorted);
      entry_arr_type          src;
      entry_arr_type          dst;
      int                     bin_start [NUM_BINS];
      int                     running;
      int                     count;
      int                     n;
      logic [DIGIT_BITS-1:0]  d;
      lrs_rsp_type            r;
      if (held_count < MAX_ENTRIES) begin
         held_entries[held_count].key = e.key;
         held_entries[held_count].payload = e.payload;
         held_count++;
      end
      if (!e.final_entry) return;
      n = held_count;
      src = held_entries;
      dst = held_entries;
      for (int pass = 0; pass < NUM_PASSES; pass++) begin
         for (int b = 0; b < NUM_BINS; b++) bin_start[b] = 0;
         for (int i = 0; i < n; i++) begin
            d = DIGIT_BITS'(src[i].key >> (pass * DIGIT_BITS));
            bin_start[d]++;
         end
         running = 0;
         for (int b = 0; b < NUM_BINS; b++) begin
            count = bin_start[b];
            bin_start[b] = running;
            running += count;
         end
         for (int i = 0; i < n; i++) begin
            d = DIGIT_BITS'(src[i].key >> (pass * DIGIT_BITS));
            dst[bin_start[d]] = src[i];
            bin_start[d]++;
         end
         src = dst;
      end
      if (queue_sorted) begin
         for (int i = 0; i < n; i++) begin
            r.sorted_key = src[i].key;
            r.sorted_payload = src[i].payload;
            r.last_out = (i == n - 1);
            sorted_due.push_back(r);
         end
      end
      held_count = 0;
   endtask

   task automatic drive_entry(input logic [KEY_BITS-1:0] key,
                              input logic [PAYLOAD_BITS-1:0] payload,
                              input logic fin, input bit queue_sorted);
      lrs_req_type e;
      e.key = key;
      e.payload = payload;
      e.final_entry = fin;
      while (!no_idle && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= e;
      do @(posedge clock); while (req_stall);
      store_entry(e, queue_sorted);
   endtask

   task automatic wait_sorted_drained();
      while (sorted_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [KEY_BITS-1:0] random_key(input int mode);
      logic [KEY_BITS-1:0] k;
      case (mode)
         0: begin
            k = {$urandom, $urandom};
         end
         1: begin
            k = KEY_BITS'($urandom_range(15));
         end
         2: begin
            k = KEY_BITS'($urandom_range(255)) << (8 * $urandom_range(7));
         end
         default: begin
            k = $urandom_range(1) ? '1 : '0;
         end
      endcase
      return k;
   endfunction

   // result side: random stall except while no_idle is set, every transfer checked against the oldest expectation
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (sorted_due.size() == 0) begin
               $display("%0t: unexpected result key %h payload %h last %b", $time,
                        rsp_data.sorted_key, rsp_data.sorted_payload, rsp_data.last_out);
               mismatch_count++;
            end else begin
               want = sorted_due.pop_front();
               if (rsp_data.sorted_key !== want.sorted_key) begin
                  $display("%0t: sorted_key expected %h actual %h", $time,
                           want.sorted_key, rsp_data.sorted_key);
                  mismatch_count++;
               end
               if (rsp_data.sorted_payload !== want.sorted_payload) begin
                  $display("%0t: sorted_payload expected %h actual %h", $time,
                           want.sorted_payload, rsp_data.sorted_payload);
                  mismatch_count++;
               end
               if (rsp_data.last_out !== want.last_out) begin
                  $display("%0t: last_out expected %b actual %b", $time,
                           want.last_out, rsp_data.last_out);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= !no_idle && ($urandom_range(99) < 23);
      end
   end

   initial begin
      int run;
      int sent;
      int len;
      int mode;
      lrs_rsp_type typed;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         drive_entry(directed_rows[i].key, directed_rows[i].payload, directed_rows[i].fin,
                     !directed_rows[i].exp_given);
         if (directed_rows[i].exp_given) begin
            typed.sorted_key = directed_rows[i].exp_key;
            typed.sorted_payload = directed_rows[i].exp_payload;
            typed.last_out = 1'b1;
            sorted_due.push_back(typed);
         end
      end

      run = 0;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (run == 3) begin
            len = MAX_ENTRIES;
            // hold off until the previous run has fully drained
            req_valid <= 1'b0;
            wait_sorted_drained();
         end else if (run == 9) begin
            // overlong run, the tail including the final entry is not kept, though the final entry still ends the run
            len = MAX_ENTRIES + $urandom_range(2, 8);
         end else begin
            len = $urandom_range(1, 12);
         end
         no_idle = (run >= 5 && run <= 7);
         mode = $urandom_range(3);
         for (int i = 0; i < len; i++) begin
            drive_entry(random_key(($urandom_range(7) == 0) ? 0 : mode), $urandom,
                        i == len - 1, 1'b1);
         end
         sent += len;
         run++;
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      wait_sorted_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && sorted_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* lsd_radix_sort_64bit_keys_top.f */
src/lrs_pkg.sv
src/lrs_entry_buf.sv
src/lrs_hist_unit.sv
src/lsd_radix_sort_64bit_keys_top.sv
src/lrs_checker.sv
test/lsd_radix_sort_64bit_keys_top_test.sv
